>>> rtl/jdc_pkg.sv
// ============================================================================
// jdc_pkg
// Shared types and constants for the joystick dead-zone conditioner.
// ============================================================================
package jdc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DEAD_BAND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PULL_IN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS     = 3'd3;

    localparam logic [6:0] RST_AXIS_DEAD_BAND = 7'd8;
    localparam logic [6:0] RST_AXIS_PULL_IN   = 7'd6;
    localparam logic [6:0] RST_MIN_RADIUS     = 7'd8;
    localparam logic [6:0] RST_MAX_RADIUS     = 7'd64;

    localparam int unsigned SQRT_STEPS = 16;
    localparam int unsigned DIV_STEPS  = 16;

    typedef struct packed {
        logic [6:0] axis_dead_band;
        logic [6:0] axis_pull_in;
        logic [6:0] min_radius;
        logic [6:0] max_radius;
    } cfg_t;

    typedef struct packed {
        logic signed [7:0] left_raw_x;
        logic signed [7:0] left_raw_y;
        logic signed [7:0] right_raw_x;
        logic signed [7:0] right_raw_y;
        logic [15:0]       button_word;
        logic              pad_absent;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic [14:0]        left_magnitude;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [14:0]        right_magnitude;
        logic [15:0]        buttons_held;
        logic [15:0]        buttons_new;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        magnitude;
    } lane_res_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_LOAD,
        LANE_SQRT,
        LANE_DIV,
        LANE_DONE
    } lane_state_t;

endpackage

>>> rtl/joystick_deadzone_conditioner_unit.sv
// Each lane loads its operands, runs a bit-serial square root (16 steps), then
// the bit-serial divide (16 steps); in_stall holds off a new transaction until
// the merge stage has taken the previous result.
// The output register frees the lanes while a result waits downstream.
// Reset: registers return to 8, 6, 8, 64; previous buttons clear to zero.
// ============================================================================
// joystick_deadzone_conditioner_unit
// Two parallel stick lanes and a merge stage for controller polls.
// ============================================================================
module joystick_deadzone_conditioner_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  jdc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output jdc_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [jdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    jdc_pkg::cfg_t      cfg_reg;
    logic               busy_reg;
    logic [15:0]        buttons_reg;
    logic               absent_reg;
    logic               start;
    logic               ack;
    logic [1:0]         lane_done;
    jdc_pkg::lane_res_t left_res, right_res;

    assign start    = in_valid && !in_stall;
    assign in_stall = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_dead_band <= jdc_pkg::RST_AXIS_DEAD_BAND;
            cfg_reg.axis_pull_in   <= jdc_pkg::RST_AXIS_PULL_IN;
            cfg_reg.min_radius     <= jdc_pkg::RST_MIN_RADIUS;
            cfg_reg.max_radius     <= jdc_pkg::RST_MAX_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jdc_pkg::CFG_AXIS_DEAD_BAND: cfg_reg.axis_dead_band <= cfg_data;
                jdc_pkg::CFG_AXIS_PULL_IN:   cfg_reg.axis_pull_in   <= cfg_data;
                jdc_pkg::CFG_MIN_RADIUS:     cfg_reg.min_radius     <= cfg_data;
                jdc_pkg::CFG_MAX_RADIUS:     cfg_reg.max_radius     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (ack)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            buttons_reg <= in_data.button_word;
            absent_reg  <= in_data.pad_absent;
        end
    end

    jdc_lane u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ack   (ack),
        .raw_x (in_data.left_raw_x),
        .raw_y (in_data.left_raw_y),
        .cfg   (cfg_reg),
        .done  (lane_done[0]),
        .res   (left_res)
    );

    jdc_lane u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ack   (ack),
        .raw_x (in_data.right_raw_x),
        .raw_y (in_data.right_raw_y),
        .cfg   (cfg_reg),
        .done  (lane_done[1]),
        .res   (right_res)
    );

    jdc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lanes_done (lane_done[0] && lane_done[1]),
        .left_res   (left_res),
        .right_res  (right_res),
        .buttons    (buttons_reg),
        .absent     (absent_reg),
        .out_stall  (out_stall),
        .ack        (ack),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] == lane_done[1])
        else $error("lanes out of step");

    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (lane_done == 2'b00))
        else $error("lane done while no transaction in flight");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (in_stall && !ack))
        else $error("new transaction not held off after accept");

    a_ack_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ack |=> out_valid)
        else $error("result lost at merge");

endmodule

>>> rtl/jdc_lane.sv
// ============================================================================
// jdc_lane
// One stick: per-axis dead band, bit-serial square root of the radius and
// two bit-serial dividers that scale the axes onto the clamp circle.
// ============================================================================
module jdc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                ack,
    input  logic [7:0]          raw_x,
    input  logic [7:0]          raw_y,
    input  jdc_pkg::cfg_t       cfg,
    output logic                done,
    output jdc_pkg::lane_res_t  res
);

    function automatic logic [7:0] dead_band(input logic [7:0] raw,
                                             input logic [6:0] band,
                                             input logic [6:0] pull);
        logic [7:0] a;
        logic [7:0] r;
        a = raw[7] ? (8'd0 - raw) : raw;
        if (a == 8'd0 || a < {1'b0, band})
            r = 8'd0;
        else if (a > {1'b0, pull})
            r = a - {1'b0, pull};
        else
            r = 8'd0;
        return r;
    endfunction

    localparam int unsigned SQRT_LAST = jdc_pkg::SQRT_STEPS - 1;

    jdc_pkg::lane_state_t state_reg, state_next;

    logic [7:0]  ax_reg, ay_reg;
    logic        nx_reg, ny_reg;
    logic [15:0] s_reg;
    logic [31:0] v_reg;
    logic [18:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic [16:0] dxr_reg, dyr_reg;
    logic [15:0] qx_reg, qy_reg;

    logic        last_step;
    logic [15:0] s_calc;
    logic [14:0] px, py;
    logic [18:0] rem_sh, trial;
    logic [16:0] dx_sh, dy_sh, root_ext;

    assign last_step = (cnt_reg == 4'(SQRT_LAST));

    assign s_calc = ({8'd0, ax_reg} * {8'd0, ax_reg}) + ({8'd0, ay_reg} * {8'd0, ay_reg});
    assign px     = {7'd0, ax_reg} * {8'd0, cfg.max_radius};
    assign py     = {7'd0, ay_reg} * {8'd0, cfg.max_radius};

    assign rem_sh   = {rem_reg[16:0], v_reg[31:30]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_ext = {1'b0, root_reg};
    assign dx_sh    = {dxr_reg[15:0], 1'b0};
    assign dy_sh    = {dyr_reg[15:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jdc_pkg::LANE_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            jdc_pkg::LANE_IDLE: if (start) state_next = jdc_pkg::LANE_LOAD;
            jdc_pkg::LANE_LOAD: state_next = jdc_pkg::LANE_SQRT;
            jdc_pkg::LANE_SQRT: if (last_step) state_next = jdc_pkg::LANE_DIV;
            jdc_pkg::LANE_DIV:  if (last_step) state_next = jdc_pkg::LANE_DONE;
            jdc_pkg::LANE_DONE:
            begin
                done = 1'b1;
                if (ack) state_next = jdc_pkg::LANE_IDLE;
            end
            default: state_next = jdc_pkg::LANE_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            jdc_pkg::LANE_IDLE:
            begin
                if (start)
                begin
                    ax_reg <= dead_band(raw_x, cfg.axis_dead_band, cfg.axis_pull_in);
                    ay_reg <= dead_band(raw_y, cfg.axis_dead_band, cfg.axis_pull_in);
                    nx_reg <= raw_x[7];
                    ny_reg <= raw_y[7];
                end
            end
            jdc_pkg::LANE_LOAD:
            begin
                s_reg    <= s_calc;
                v_reg    <= {s_calc, 16'd0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                dxr_reg  <= {2'd0, px};
                dyr_reg  <= {2'd0, py};
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            jdc_pkg::LANE_SQRT:
            begin
                v_reg   <= {v_reg[29:0], 2'b00};
                cnt_reg <= cnt_reg + 4'd1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[14:0], 1'b0};
                end
            end
            jdc_pkg::LANE_DIV:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (dx_sh >= root_ext)
                begin
                    dxr_reg <= dx_sh - root_ext;
                    qx_reg  <= {qx_reg[14:0], 1'b1};
                end
                else
                begin
                    dxr_reg <= dx_sh;
                    qx_reg  <= {qx_reg[14:0], 1'b0};
                end
                if (dy_sh >= root_ext)
                begin
                    dyr_reg <= dy_sh - root_ext;
                    qy_reg  <= {qy_reg[14:0], 1'b1};
                end
                else
                begin
                    dyr_reg <= dy_sh;
                    qy_reg  <= {qy_reg[14:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    logic [13:0] min_sq, max_sq;
    logic        lt_min, gt_max;
    logic [14:0] lim;
    logic [15:0] mx, my;

    assign min_sq = {7'd0, cfg.min_radius} * {7'd0, cfg.min_radius};
    assign max_sq = {7'd0, cfg.max_radius} * {7'd0, cfg.max_radius};
    assign lt_min = s_reg < {2'd0, min_sq};
    assign gt_max = s_reg > {2'd0, max_sq};
    assign lim    = {cfg.max_radius, 8'd0};

    always_comb
    begin
        if (!lt_min && gt_max)
        begin
            mx            = (qx_reg > {1'b0, lim}) ? {1'b0, lim} : qx_reg;
            my            = (qy_reg > {1'b0, lim}) ? {1'b0, lim} : qy_reg;
            res.magnitude = lim;
        end
        else
        begin
            mx            = {ax_reg, 8'd0};
            my            = {ay_reg, 8'd0};
            res.magnitude = lt_min ? 15'd0 : root_reg[14:0];
        end
        res.x = nx_reg ? (16'sd0 - $signed(mx)) : $signed(mx);
        res.y = ny_reg ? (16'sd0 - $signed(my)) : $signed(my);
    end

endmodule

>>> rtl/jdc_merge.sv
// ============================================================================
// jdc_merge
// Combine both lane results with button edge detection into the output
// register, or zeroes when the pad is absent; hold the previous button word.
// ============================================================================
module jdc_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lanes_done,
    input  jdc_pkg::lane_res_t  left_res,
    input  jdc_pkg::lane_res_t  right_res,
    input  logic [15:0]         buttons,
    input  logic                absent,
    input  logic                out_stall,
    output logic                ack,
    output logic                out_valid,
    output jdc_pkg::out_item_t  out_data
);

    logic               out_valid_reg;
    jdc_pkg::out_item_t out_data_reg, out_data_next;
    logic [15:0]        prev_buttons_reg, prev_buttons_next;

    assign ack       = lanes_done && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (absent)
        begin
            out_data_next     = '0;
            prev_buttons_next = '0;
        end
        else
        begin
            out_data_next.left_x          = left_res.x;
            out_data_next.left_y          = left_res.y;
            out_data_next.left_magnitude  = left_res.magnitude;
            out_data_next.right_x         = right_res.x;
            out_data_next.right_y         = right_res.y;
            out_data_next.right_magnitude = right_res.magnitude;
            out_data_next.buttons_held    = buttons;
            out_data_next.buttons_new     = buttons & ~prev_buttons_reg;
            prev_buttons_next             = buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            prev_buttons_reg <= '0;
        end
        else if (ack)
        begin
            out_valid_reg    <= 1'b1;
            prev_buttons_reg <= prev_buttons_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
            out_data_reg <= out_data_next;
    end

endmodule

>>> tb/jdc_poll_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// jdc_poll_checker
// Watches the poll, result and register channels of the conditioner. Each
// accepted poll is run through a local model of the dead band, the radial
// clamp and the button edge logic, and the outcome is queued. Each accepted
// result is compared field by field with the oldest queued outcome.
// ============================================================================
module jdc_poll_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  jdc_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  jdc_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jdc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);

    localparam int unsigned PRINT_CAP = 120;

    jdc_pkg::cfg_t      live_cfg;
    logic [15:0]        prev_buttons;
    jdc_pkg::out_item_t conditioned_polls[$];
    int unsigned        errors = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [7:0] axis_live_mag(input logic [7:0] raw,
                                                 input logic [6:0] band,
                                                 input logic [6:0] pull);
        logic [7:0] mag;
        mag = raw[7] ? 8'd0 - raw : raw;
        if (mag == 8'd0 || mag < {1'b0, band})
            return 8'd0;
        return (mag > {1'b0, pull}) ? mag - {1'b0, pull} : 8'd0;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v)
                acc = trial;
        end
        return acc;
    endfunction

    function automatic jdc_pkg::lane_res_t shape_stick(input logic [7:0] rx,
                                                       input logic [7:0] ry,
                                                       input jdc_pkg::cfg_t c);
        logic [7:0]         ax;
        logic [7:0]         ay;
        longint unsigned    s;
        longint unsigned    r;
        longint unsigned    lim;
        longint unsigned    qx;
        longint unsigned    qy;
        logic [15:0]        ox;
        logic [15:0]        oy;
        jdc_pkg::lane_res_t res;
        ax  = axis_live_mag(rx, c.axis_dead_band, c.axis_pull_in);
        ay  = axis_live_mag(ry, c.axis_dead_band, c.axis_pull_in);
        s   = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        r   = root_floor(s << 16);
        lim = 64'(c.max_radius) << 8;
        ox  = {ax, 8'h00};
        oy  = {ay, 8'h00};
        res = '0;
        if (s < 64'(c.min_radius) * 64'(c.min_radius)) begin
            res.magnitude = '0;
        end else if (s > 64'(c.max_radius) * 64'(c.max_radius)) begin
            qx = (r != 0) ? ((64'(ax) * 64'(c.max_radius)) << 16) / r : 0;
            qy = (r != 0) ? ((64'(ay) * 64'(c.max_radius)) << 16) / r : 0;
            if (qx > lim)
                qx = lim;
            if (qy > lim)
                qy = lim;
            ox = 16'(qx);
            oy = 16'(qy);
            res.magnitude = 15'(lim);
        end else begin
            res.magnitude = 15'(r);
        end
        res.x = rx[7] ? 16'h0000 - ox : ox;
        res.y = ry[7] ? 16'h0000 - oy : oy;
        return res;
    endfunction

    function automatic jdc_pkg::out_item_t predict_poll(input jdc_pkg::in_item_t p,
                                                        input jdc_pkg::cfg_t c,
                                                        input logic [15:0] prev);
        jdc_pkg::out_item_t r;
        jdc_pkg::lane_res_t lane_l;
        jdc_pkg::lane_res_t lane_r;
        r = '0;
        if (!p.pad_absent) begin
            lane_l            = shape_stick(p.left_raw_x, p.left_raw_y, c);
            lane_r            = shape_stick(p.right_raw_x, p.right_raw_y, c);
            r.left_x          = lane_l.x;
            r.left_y          = lane_l.y;
            r.left_magnitude  = lane_l.magnitude;
            r.right_x         = lane_r.x;
            r.right_y         = lane_r.y;
            r.right_magnitude = lane_r.magnitude;
            r.buttons_held    = p.button_word;
            r.buttons_new     = p.button_word & ~prev;
        end
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        jdc_pkg::out_item_t want;
        jdc_pkg::out_item_t got;
        if (!rst_n) begin
            live_cfg = '{jdc_pkg::RST_AXIS_DEAD_BAND, jdc_pkg::RST_AXIS_PULL_IN,
                         jdc_pkg::RST_MIN_RADIUS, jdc_pkg::RST_MAX_RADIUS};
            prev_buttons = '0;
            conditioned_polls.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    jdc_pkg::CFG_AXIS_DEAD_BAND: live_cfg.axis_dead_band = cfg_data;
                    jdc_pkg::CFG_AXIS_PULL_IN:   live_cfg.axis_pull_in   = cfg_data;
                    jdc_pkg::CFG_MIN_RADIUS:     live_cfg.min_radius     = cfg_data;
                    jdc_pkg::CFG_MAX_RADIUS:     live_cfg.max_radius     = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                got = out_data;
                if (conditioned_polls.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_CAP)
                        $display("%0t ns: unexpected transaction, expected none, actual %h",
                                 $time, got);
                end else begin
                    want = conditioned_polls.pop_front();
                    compare_field("left_x", want.left_x, got.left_x);
                    compare_field("left_y", want.left_y, got.left_y);
                    compare_field("left_magnitude", 16'(want.left_magnitude),
                                  16'(got.left_magnitude));
                    compare_field("right_x", want.right_x, got.right_x);
                    compare_field("right_y", want.right_y, got.right_y);
                    compare_field("right_magnitude", 16'(want.right_magnitude),
                                  16'(got.right_magnitude));
                    compare_field("buttons_held", want.buttons_held, got.buttons_held);
                    compare_field("buttons_new", want.buttons_new, got.buttons_new);
                end
            end
            if (in_valid && !in_stall) begin
                conditioned_polls.push_back(predict_poll(in_data, live_cfg, prev_buttons));
                prev_buttons = in_data.pad_absent ? 16'h0000 : in_data.button_word;
            end
        end
        fail_count <= errors;
        pending    <= conditioned_polls.size();
    end

endmodule

>>> tb/joystick_deadzone_conditioner_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// joystick_deadzone_conditioner_unit_tb
// Drives controller polls through the conditioner under a series of register
// settings: an opening set of corner polls, then shaped random polls, with
// random gaps and stalls on both channels, a stretch without gaps and one
// long hold-off on the result side. The checker judges every result.
// ============================================================================
module joystick_deadzone_conditioner_unit_tb;

    localparam int unsigned HALF_PERIOD  = 5;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    jdc_pkg::in_item_t              in_data;
    logic                           out_valid;
    logic                           out_stall;
    jdc_pkg::out_item_t             out_data;
    logic                           cfg_we;
    logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [jdc_pkg::CFG_DATA_W-1:0] cfg_data;
    int unsigned                    fail_count;
    int unsigned                    pending;

    bit          gaps_on;
    bit          squeeze;
    logic [15:0] last_buttons;

    joystick_deadzone_conditioner_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jdc_poll_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic jdc_pkg::in_item_t poll(input logic [7:0] lx, input logic [7:0] ly,
                                               input logic [7:0] rx, input logic [7:0] ry,
                                               input logic [15:0] buttons,
                                               input logic absent);
        jdc_pkg::in_item_t p;
        p.left_raw_x  = lx;
        p.left_raw_y  = ly;
        p.right_raw_x = rx;
        p.right_raw_y = ry;
        p.button_word = buttons;
        p.pad_absent  = absent;
        return p;
    endfunction

    function automatic logic [7:0] random_axis();
        logic [7:0] m;
        case ($urandom_range(0, 9))
            0:       m = 8'h80;
            1:       m = 8'h7F;
            2, 3:    m = 8'($urandom_range(0, 24));
            4, 5:    m = 8'($urandom_range(40, 110));
            default: m = 8'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1 && m != 8'h80)
            m = 8'd0 - m;
        return m;
    endfunction

    function automatic jdc_pkg::in_item_t random_poll();
        jdc_pkg::in_item_t p;
        if ($urandom_range(0, 3) == 0)
            last_buttons = 16'($urandom);
        else
            last_buttons = last_buttons ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
        p = poll(random_axis(), random_axis(), random_axis(), random_axis(), last_buttons,
                 $urandom_range(0, 11) == 0);
        return p;
    endfunction

    task automatic send_poll(input jdc_pkg::in_item_t p);
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [6:0] band, input logic [6:0] pull,
                            input logic [6:0] rmin, input logic [6:0] rmax);
        logic [jdc_pkg::CFG_IDX_W-1:0] idx [4];
        logic [6:0]                    vals [4];
        idx  = '{jdc_pkg::CFG_AXIS_DEAD_BAND, jdc_pkg::CFG_AXIS_PULL_IN,
                 jdc_pkg::CFG_MIN_RADIUS, jdc_pkg::CFG_MAX_RADIUS};
        vals = '{band, pull, rmin, rmax};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        // unmapped index: must leave every register alone
        cfg_index <= jdc_pkg::CFG_MAX_RADIUS
                     + jdc_pkg::CFG_IDX_W'($urandom_range(1, 4));
        cfg_data  <= 7'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_corner_polls(input logic [6:0] band);
        logic [7:0] edge_on;
        logic [7:0] edge_off;
        edge_on  = {1'b0, band};
        edge_off = {1'b0, band} - 8'd1;
        send_poll(poll(8'h80, 8'h80, 8'h7F, 8'h7F, 16'hFFFF, 1'b0));
        send_poll(poll(edge_on, 8'd0 - edge_on, edge_off, 8'd0 - edge_off, 16'h0000, 1'b0));
        send_poll(poll(8'h7F, 8'h80, 8'hFF, 8'h01, 16'($urandom), 1'b0));
        send_poll(poll(8'h00, 8'h00, 8'h00, 8'h00, 16'($urandom), 1'b0));
        send_poll(poll(8'h80, 8'h7F, 8'h80, 8'h7F, 16'hFFFF, 1'b1));
    endtask

    task automatic run_phase(input logic [6:0] band, input logic [6:0] pull,
                             input logic [6:0] rmin, input logic [6:0] rmax,
                             input int unsigned n_random);
        settle();
        set_regs(band, pull, rmin, rmax);
        send_corner_polls(band);
        repeat (n_random) send_poll(random_poll());
    endtask

    task automatic send_opening_polls();
        send_poll(poll(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
        send_poll(poll(8'h7F, 8'h7F, 8'h80, 8'h80, 16'hFFFF, 1'b0));
        send_poll(poll(8'h80, 8'h7F, 8'h7F, 8'h80, 16'hFFFF, 1'b0));
        send_poll(poll(8'(7), 8'(-7), 8'(8), 8'(-8), 16'h0000, 1'b0));
        send_poll(poll(8'(-8), 8'(8), 8'(-7), 8'(7), 16'h8001, 1'b0));
        send_poll(poll(8'(9), 8'(9), 8'(-9), 8'(-9), 16'h0100, 1'b0));
        send_poll(poll(8'(14), 8'(0), 8'(0), 8'(-14), 16'h0100, 1'b0));
        send_poll(poll(8'(70), 8'(0), 8'(0), 8'(-70), 16'h0F0F, 1'b0));
        send_poll(poll(8'(71), 8'(0), 8'(0), 8'(-71), 16'hF0F0, 1'b0));
        send_poll(poll(8'(100), 8'(-100), 8'(-50), 8'(90), 16'hFFFF, 1'b0));
        send_poll(poll(8'(127), 8'(1), 8'(-1), 8'(-128), 16'h1234, 1'b0));
        send_poll(poll(8'(55), 8'(-55), 8'(30), 8'(-30), 16'hAAAA, 1'b1));
        send_poll(poll(8'(20), 8'(20), 8'(-20), 8'(20), 16'h5555, 1'b0));
        send_poll(poll(8'(-40), 8'(44), 8'(60), 8'(-12), 16'hFFFF, 1'b0));
        send_poll(poll(8'h80, 8'h80, 8'h80, 8'h80, 16'hFFFF, 1'b1));
        send_poll(poll(8'(1), 8'(-1), 8'(6), 8'(-6), 16'h0001, 1'b0));
        send_poll(poll(8'(45), 8'(45), 8'(-46), 8'(46), 16'h8000, 1'b0));
        send_poll(poll(8'(-128), 8'(0), 8'(0), 8'(127), 16'h7FFF, 1'b0));
    endtask

    initial begin : receiver
        int unsigned hold_left;
        bit          squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (squeeze && !squeezed) begin
                hold_left = HOLD_CYCLES;
                squeezed  = 1'b1;
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= gaps_on && ($urandom_range(0, 99) < 33);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("joystick_deadzone_conditioner_unit_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = jdc_pkg::CFG_AXIS_DEAD_BAND;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        squeeze      = 1'b0;
        last_buttons = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_opening_polls();

        run_phase(7'd0, 7'd0, 7'd0, 7'd127, 100);
        run_phase(7'd127, 7'd127, 7'd127, 7'd1, 100);
        run_phase(7'd0, 7'd127, 7'd0, 7'd64, 100);
        run_phase(7'd20, 7'd4, 7'd40, 7'd10, 100);
        run_phase(7'd8, 7'd6, 7'd8, 7'd0, 100);

        gaps_on = 1'b0;
        run_phase(7'd10, 7'd2, 7'd5, 7'd100, 150);
        gaps_on = 1'b1;

        settle();
        squeeze = 1'b1;
        run_phase(7'd8, 7'd6, 7'd8, 7'd64, 150);

        repeat (4) run_phase(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 100);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("joystick_deadzone_conditioner_unit_tb: done, clean");
        else
            $display("joystick_deadzone_conditioner_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/jdc_pkg.sv
rtl/jdc_lane.sv
rtl/jdc_merge.sv
rtl/joystick_deadzone_conditioner_unit.sv
tb/jdc_poll_checker.sv
tb/joystick_deadzone_conditioner_unit_tb.sv
